// ===== sv/lisa_pkg.sv =====
// Shared types and constants for the lattice index score accumulator.
package lisa_pkg;
	localparam int FRAC_BITS = 44;
	localparam int NUM_SUMS  = 19;
	localparam int CNT_W     = 21;

	typedef enum logic [2:0] {
		REG_PAIR0 = 3'd0,
		REG_PAIR1 = 3'd1,
		REG_PAIR2 = 3'd2,
		REG_PAIR3 = 3'd3,
		REG_LAST  = 3'd4,
		REG_TOL   = 3'd5
	} reg_idx_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       mul;
		logic       acc;
		logic [1:0] comp;
		logic       rnd;
		logic       upd;
		logic [1:0] uidx;
		logic       clr;
	} cmd_t;
endpackage

// ===== sv/lisa_ctrl.sv =====
// Controller sequencing one item through the datapath and the result emission.
module lisa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_fire,
	input  logic          in_last,
	input  logic          out_fire,
	output logic          busy,
	output logic          emit,
	output logic [4:0]    emit_idx,
	output lisa_pkg::cmd_t cmd
);
	import lisa_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_RND, S_UPD, S_EMIT} state_t;
	state_t state_q;
	logic [1:0] comp_q;
	logic [1:0] term_q;
	logic [1:0] uidx_q;
	logic       last_q;
	logic [4:0] idx_q;

	assign busy     = (state_q != S_IDLE);
	assign emit     = (state_q == S_EMIT);
	assign emit_idx = idx_q;

	always_comb begin
		cmd      = '0;
		cmd.load = in_fire;
		cmd.comp = comp_q;
		cmd.uidx = uidx_q;
		case (state_q)
			S_MUL: cmd.mul = 1'b1;
			S_ACC: cmd.acc = 1'b1;
			S_RND: cmd.rnd = 1'b1;
			S_UPD: cmd.upd = 1'b1;
			S_EMIT: cmd.clr = out_fire && (idx_q == 5'(NUM_SUMS - 1));
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			comp_q  <= '0;
			term_q  <= '0;
			uidx_q  <= '0;
			last_q  <= 1'b0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire) begin
					state_q <= S_MUL;
					comp_q  <= '0;
					term_q  <= '0;
					last_q  <= in_last;
				end
				// Three product terms per component go through the shared multiplier.
				S_MUL: if (term_q == 2'd2) begin
					term_q  <= '0;
					state_q <= S_ACC;
				end else begin
					term_q <= term_q + 2'd1;
				end
				S_ACC: if (comp_q == 2'd2) begin
					state_q <= S_RND;
				end else begin
					comp_q  <= comp_q + 2'd1;
					state_q <= S_MUL;
				end
				S_RND: begin
					state_q <= S_UPD;
					uidx_q  <= '0;
				end
				S_UPD: if (uidx_q == 2'd2) begin
					idx_q   <= '0;
					state_q <= last_q ? S_EMIT : S_IDLE;
				end else begin
					uidx_q <= uidx_q + 2'd1;
				end
				S_EMIT: if (out_fire) begin
					if (idx_q == 5'(NUM_SUMS - 1)) state_q <= S_IDLE;
					else idx_q <= idx_q + 5'd1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/lisa_dp.sv =====
// Datapath: matrix product, rounding, error and the accumulators.
module lisa_dp #(
	parameter int CNT_LIMIT = 1048576
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lisa_pkg::cmd_t         cmd,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_idx,
	input  logic [63:0]            cfg_data,
	input  logic signed [31:0]     in_gx,
	input  logic signed [31:0]     in_gy,
	input  logic signed [31:0]     in_gz,
	input  logic [4:0]             emit_idx,
	output logic signed [63:0]     emit_value,
	output logic [lisa_pkg::CNT_W-1:0] emit_count
);
	import lisa_pkg::*;

	logic [63:0] pair_q [4];
	logic [31:0] mlast_q, tol_q;
	logic signed [31:0] g_q [3];
	logic [1:0] term_q;
	logic signed [63:0] prod_s1;
	logic signed [67:0] h_q;
	logic signed [67:0] hc_q [3];
	logic signed [23:0] n_q [3];
	logic [33:0] s_q;
	logic        hit_q;
	logic [63:0] outer_q [9];
	logic [63:0] cross_q [9];
	logic [63:0] err_q;
	logic [CNT_W-1:0] cnt_q;

	localparam int LIM = (CNT_LIMIT < 2097151) ? CNT_LIMIT : 2097151;

	// Matrix entry for row comp, column term.
	logic [3:0] m_sel;
	logic signed [31:0] m_ent, g_ent;
	assign m_sel = 4'(cmd.comp) * 4'd3 + 4'(term_q);
	always_comb begin
		case (m_sel)
			4'd0: m_ent = pair_q[0][31:0];
			4'd1: m_ent = pair_q[0][63:32];
			4'd2: m_ent = pair_q[1][31:0];
			4'd3: m_ent = pair_q[1][63:32];
			4'd4: m_ent = pair_q[2][31:0];
			4'd5: m_ent = pair_q[2][63:32];
			4'd6: m_ent = pair_q[3][31:0];
			4'd7: m_ent = pair_q[3][63:32];
			default: m_ent = mlast_q;
		endcase
		g_ent = g_q[term_q];
	end

	// All three components are rounded together in the rnd state.
	logic signed [23:0] n_c [3];
	logic [33:0] sq_sum;
	always_comb begin
		logic [43:0] fr;
		logic signed [23:0] ip;
		logic up;
		logic [43:0] mag;
		logic [32:0] q;
		logic [65:0] qq;
		sq_sum = '0;
		for (int i = 0; i < 3; i++) begin
			fr  = hc_q[i][43:0];
			ip  = hc_q[i][67:44];
			up  = (fr > 44'h80000000000) || (fr == 44'h80000000000 && ip[0]);
			n_c[i] = up ? ip + 24'sd1 : ip;
			mag = up ? (44'd0 - fr) : fr;
			if (up && fr == '0) mag = '0;
			q   = 33'((45'(mag) + 45'd2048) >> 12);
			qq  = 66'(q) * 66'(q);
			sq_sum = sq_sum + 34'((qq + 66'h80000000) >> 32);
		end
	end

	// Product terms for the accumulator update of row uidx.
	logic signed [47:0] oprod [3];
	logic signed [55:0] cprod [3];
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			oprod[j] = n_q[cmd.uidx] * n_q[j];
			cprod[j] = n_q[j] * g_q[cmd.uidx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) pair_q[i] <= '0;
			mlast_q <= '0;
			tol_q   <= '0;
			for (int i = 0; i < 9; i++) begin
				outer_q[i] <= '0;
				cross_q[i] <= '0;
			end
			err_q <= '0;
			cnt_q <= '0;
			term_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_PAIR0: pair_q[0] <= cfg_data;
					REG_PAIR1: pair_q[1] <= cfg_data;
					REG_PAIR2: pair_q[2] <= cfg_data;
					REG_PAIR3: pair_q[3] <= cfg_data;
					REG_LAST:  mlast_q   <= cfg_data[31:0];
					REG_TOL:   tol_q     <= cfg_data[31:0];
					default: ;
				endcase
			end
			if (cmd.load) term_q <= '0;
			if (cmd.mul) term_q <= (term_q == 2'd2) ? 2'd0 : term_q + 2'd1;
			if (cmd.upd) begin
				for (int j = 0; j < 3; j++) begin
					if (hit_q) begin
						outer_q[4'(3*cmd.uidx+j)] <= outer_q[4'(3*cmd.uidx+j)] + 64'(oprod[j]);
						cross_q[4'(3*cmd.uidx+j)] <= cross_q[4'(3*cmd.uidx+j)] + 64'(cprod[j]);
					end
				end
				if (hit_q && cmd.uidx == 2'd0) begin
					err_q <= err_q + 64'(s_q);
					if (cnt_q < CNT_W'(LIM)) cnt_q <= cnt_q + 1'b1;
				end
			end
			if (cmd.clr) begin
				for (int i = 0; i < 9; i++) begin
					outer_q[i] <= '0;
					cross_q[i] <= '0;
				end
				err_q <= '0;
				cnt_q <= '0;
			end
		end
	end

	// The three product terms of one component are summed over successive cycles.
	logic busy_mul_s1;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			g_q[0] <= in_gx;
			g_q[1] <= in_gy;
			g_q[2] <= in_gz;
		end
		if (cmd.mul) prod_s1 <= m_ent * g_ent;
		busy_mul_s1 <= cmd.mul;
		if (cmd.acc) begin
			h_q <= '0;
			hc_q[cmd.comp] <= h_q + 68'(prod_s1);
		end else if (busy_mul_s1 && !cmd.acc) begin
			h_q <= h_q + 68'(prod_s1);
		end
		if (cmd.load) h_q <= '0;
		if (cmd.rnd) begin
			for (int i = 0; i < 3; i++) n_q[i] <= n_c[i];
			s_q   <= sq_sum;
			hit_q <= (sq_sum < 34'(tol_q));
		end
	end

	always_comb begin
		if (emit_idx < 5'd9) emit_value = outer_q[4'(emit_idx)];
		else if (emit_idx < 5'd18) emit_value = cross_q[4'(emit_idx - 5'd9)];
		else emit_value = err_q;
	end
	assign emit_count = cnt_q;
endmodule

// ===== sv/lattice_index_score_accumulator_core.sv =====
// Top level of the lattice index score accumulator.
// Channel | Dir | Content
// s_axis  | in  | tdata: g_x[31:0], g_y[63:32], g_z[95:64]; tlast: last
// m_axis  | out | tdata: value[63:0], match_count[84:64]; tuser: entry_index; tlast
// cfg     | in  | we, idx, data (64 bit)
// Each item runs from one input acceptance to the next through the accept step,
// then for each component three multiplies on one shared 32x32 multiplier and
// an add, then a rounding step and three accumulator rows; s_axis_tready is low meanwhile.
// A last item then emits 19 results at full output rate; m_axis_tready stalls them.
// Reset clears the configuration registers, sums and the count.
module lattice_index_score_accumulator_core #(
	parameter int MAX_ITEMS = 1048576
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [95:0]  s_axis_tdata,  // g_x, g_y, g_z
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [87:0]  m_axis_tdata,  // value, match_count, zero fill
	output logic [4:0]   m_axis_tuser,  // entry_index
	output logic         m_axis_tlast,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_idx,
	input  logic [63:0]  cfg_data
);
	import lisa_pkg::*;

	cmd_t cmd;
	logic busy, emit, in_fire, out_fire;
	logic [4:0] emit_idx;
	logic signed [63:0] emit_value;
	logic [CNT_W-1:0] emit_count;

	assign s_axis_tready = !busy;
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = emit;
	assign out_fire = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata = {3'b000, emit_count, emit_value};
	assign m_axis_tuser = emit_idx;
	assign m_axis_tlast = emit_idx == 5'(NUM_SUMS - 1);

	lisa_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .in_last(s_axis_tlast), .out_fire,
		.busy, .emit, .emit_idx, .cmd
	);

	lisa_dp #(.CNT_LIMIT(MAX_ITEMS)) u_dp (
		.clk, .arst_n, .cmd, .cfg_we, .cfg_idx, .cfg_data,
		.in_gx(s_axis_tdata[31:0]), .in_gy(s_axis_tdata[63:32]),
		.in_gz(s_axis_tdata[95:64]), .emit_idx, .emit_value, .emit_count
	);

	a_no_accept_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_fire) else $error("item taken while busy");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser < 5'(NUM_SUMS)) else $error("bad entry index");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && m_axis_tlast) |=> !m_axis_tvalid) else $error("emit after last");
endmodule
